### sv/mex_pkg.sv
// Shared types, codes and defaults for the mutual exclusion node.
`timescale 1ns / 1ps
`default_nettype none

package mex_pkg;

   // Default sizes of the node
   localparam int MAX_NODES_DEF  = 16;
   localparam int STAMP_BITS_DEF = 16;

   // Fixed field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 4;
   localparam int STAMP_W  = 16;
   localparam int COUNT_W  = 5;
   localparam int ERR_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;

   // Saturation value of the reply and done counters
   localparam logic [COUNT_W-1:0] CNT_MAX = 5'd31;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ID     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

   // Reset values of the registers
   localparam logic [ID_W-1:0]    OWN_ID_RST     = 4'd1;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd2;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RELEASE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

   // Message kinds
   typedef enum logic [CMD_W-1:0] {
      CMD_ENTER   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_REQUEST = 3'd2,
      CMD_REPLY   = 3'd3,
      CMD_DONE    = 3'd4,
      CMD_OTHER   = 3'd5
   } cmd_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic ld_in;      // latch the accepted input
      logic exec;       // run a single-result message, load the output
      logic rel_start;  // take deferred peers into the drain mask
      logic emit;       // send a reply to the current drain index
      logic skip;       // step past a clear drain index
   } ctrl_type;

   // Datapath to controller
   typedef struct packed {
      logic rel_pend;   // release with deferred peers in range
      logic bit_set;    // drain mask bit at current index is set
      logic emit_last;  // current bit is the last one left
   } stat_type;

endpackage

`default_nettype wire

### sv/mex_datapath.sv
// Datapath: node state, registers, input latch, drain scan and output register.
`timescale 1ns / 1ps
`default_nettype none

module mex_datapath #(
   parameter int MAX_NODES  = mex_pkg::MAX_NODES_DEF,
   parameter int STAMP_BITS = mex_pkg::STAMP_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [mex_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mex_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [mex_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [mex_pkg::ID_W-1:0]          req_sender,
   input  wire logic [mex_pkg::STAMP_W-1:0]       req_stamp,
   input  wire mex_pkg::ctrl_type                 ctrl,
   output mex_pkg::stat_type                      stat,
   output logic                                   rsp_send_reply,
   output logic [mex_pkg::ID_W-1:0]               rsp_reply_to,
   output logic                                   rsp_broadcast_request,
   output logic                                   rsp_granted,
   output logic [mex_pkg::ERR_W-1:0]              rsp_error_code,
   output logic [mex_pkg::COUNT_W-1:0]            rsp_done_total,
   output logic                                   rsp_last
);

   localparam int SW = (STAMP_BITS < mex_pkg::STAMP_W) ? STAMP_BITS : mex_pkg::STAMP_W;
   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = mex_pkg::COUNT_W;

   // Configuration registers
   logic [mex_pkg::ID_W-1:0] own_id_ff;
   logic [CW-1:0]            node_count_ff;

   // Node state
   logic                 requesting_ff, requesting_in;
   logic [SW-1:0]        own_stamp_ff, own_stamp_in;
   logic [CW-1:0]        reply_count_ff, reply_count_in;
   logic [MAX_NODES-1:0] deferred_ff, deferred_in;
   logic [CW-1:0]        done_count_ff, done_count_in;

   // Latched input
   logic [mex_pkg::CMD_W-1:0] in_cmd_ff;
   logic [mex_pkg::ID_W-1:0]  in_sender_ff;
   logic [SW-1:0]             in_stamp_ff;

   // Drain scan
   logic [MAX_NODES-1:0] pend_ff, pend_in;
   logic [IW-1:0]        idx_ff, idx_in;

   // Output register
   logic                       out_send_ff, out_send_in;
   logic [mex_pkg::ID_W-1:0]   out_to_ff, out_to_in;
   logic                       out_bc_ff, out_bc_in;
   logic                       out_grant_ff, out_grant_in;
   logic [mex_pkg::ERR_W-1:0]  out_err_ff, out_err_in;
   logic [CW-1:0]              out_done_ff, out_done_in;
   logic                       out_last_ff, out_last_in;

   // Helpers
   logic [MAX_NODES-1:0] range_mask;
   logic [MAX_NODES-1:0] sender_bit;
   logic [MAX_NODES-1:0] idx_onehot;
   logic [MAX_NODES-1:0] pend_calc;
   logic [CW-1:0]        need;
   logic [CW-1:0]        reply_sat;
   logic [CW-1:0]        done_sat;
   logic                 grant_now;
   logic                 answer;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= mex_pkg::OWN_ID_RST;
         node_count_ff <= mex_pkg::NODE_COUNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mex_pkg::REG_OWN_ID:     own_id_ff     <= csr_wdata[mex_pkg::ID_W-1:0];
            mex_pkg::REG_NODE_COUNT: node_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Peers in range, sender select and drain index select
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         range_mask[i] = (i != 0) && (32'(i) < 32'(node_count_ff));
         sender_bit[i] = (32'(i) == 32'(in_sender_ff));
         idx_onehot[i] = (32'(i) == 32'(idx_ff));
      end
   end

   assign pend_calc = deferred_ff & range_mask;
   assign need      = (node_count_ff >= 5'd2) ? (node_count_ff - 5'd2) : '0;
   assign reply_sat = (reply_count_ff == mex_pkg::CNT_MAX) ? reply_count_ff
                                                          : reply_count_ff + 5'd1;
   assign done_sat  = (done_count_ff == mex_pkg::CNT_MAX) ? done_count_ff
                                                         : done_count_ff + 5'd1;
   assign grant_now = requesting_ff && (reply_count_ff >= need);
   assign answer    = !requesting_ff || (in_stamp_ff < own_stamp_ff) ||
                      ((in_sender_ff < own_id_ff) && (in_stamp_ff == own_stamp_ff));

   // Status toward the controller
   assign stat.rel_pend  = (mex_pkg::cmd_type'(in_cmd_ff) == mex_pkg::CMD_RELEASE) &&
                           requesting_ff && (pend_calc != '0);
   assign stat.bit_set   = |(pend_ff & idx_onehot);
   assign stat.emit_last = ((pend_ff & ~idx_onehot) == '0);

   // Next state and output values
   always_comb begin
      requesting_in  = requesting_ff;
      own_stamp_in   = own_stamp_ff;
      reply_count_in = reply_count_ff;
      deferred_in    = deferred_ff;
      done_count_in  = done_count_ff;
      pend_in        = pend_ff;
      idx_in         = idx_ff;
      out_send_in    = out_send_ff;
      out_to_in      = out_to_ff;
      out_bc_in      = out_bc_ff;
      out_grant_in   = out_grant_ff;
      out_err_in     = out_err_ff;
      out_done_in    = out_done_ff;
      out_last_in    = out_last_ff;

      if (ctrl.exec) begin
         out_send_in  = 1'b0;
         out_to_in    = '0;
         out_bc_in    = 1'b0;
         out_grant_in = grant_now;
         out_err_in   = mex_pkg::ERR_NONE;
         out_done_in  = done_count_ff;
         out_last_in  = 1'b1;
         unique case (mex_pkg::cmd_type'(in_cmd_ff))
            mex_pkg::CMD_ENTER: begin
               own_stamp_in   = in_stamp_ff;
               requesting_in  = 1'b1;
               reply_count_in = '0;
               out_bc_in      = 1'b1;
               out_grant_in   = (need == '0);
            end
            mex_pkg::CMD_RELEASE: begin
               // no deferred peers in range here: either idle or nothing to drain
               requesting_in = 1'b0;
               out_grant_in  = 1'b0;
               if (!requesting_ff) begin
                  out_err_in = mex_pkg::ERR_RELEASE;
               end
            end
            mex_pkg::CMD_REQUEST: begin
               if (answer) begin
                  out_send_in = 1'b1;
                  out_to_in   = in_sender_ff;
               end else begin
                  deferred_in = deferred_ff | sender_bit;
               end
            end
            mex_pkg::CMD_REPLY: begin
               reply_count_in = reply_sat;
               out_grant_in   = requesting_ff && (reply_sat >= need);
            end
            mex_pkg::CMD_DONE: begin
               done_count_in = done_sat;
               out_done_in   = done_sat;
            end
            default: begin
               out_err_in = mex_pkg::ERR_UNKNOWN;
            end
         endcase
      end

      // Take deferred peers out of the mask and start the scan at peer 1
      if (ctrl.rel_start) begin
         requesting_in = 1'b0;
         deferred_in   = deferred_ff & ~pend_calc;
         pend_in       = pend_calc;
         idx_in        = IW'(1);
      end

      // Send one reply and clear its bit
      if (ctrl.emit) begin
         out_send_in  = 1'b1;
         out_to_in    = mex_pkg::ID_W'(idx_ff);
         out_bc_in    = 1'b0;
         out_grant_in = 1'b0;
         out_err_in   = mex_pkg::ERR_NONE;
         out_done_in  = done_count_ff;
         out_last_in  = stat.emit_last;
         pend_in      = pend_ff & ~idx_onehot;
         idx_in       = idx_ff + IW'(1);
      end

      if (ctrl.skip) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         requesting_ff  <= 1'b0;
         own_stamp_ff   <= '0;
         reply_count_ff <= '0;
         deferred_ff    <= '0;
         done_count_ff  <= '0;
      end else begin
         requesting_ff  <= requesting_in;
         own_stamp_ff   <= own_stamp_in;
         reply_count_ff <= reply_count_in;
         deferred_ff    <= deferred_in;
         done_count_ff  <= done_count_in;
      end
   end

   // Input latch, scan and output payload
   always_ff @(posedge clock) begin
      if (ctrl.ld_in) begin
         in_cmd_ff    <= req_cmd;
         in_sender_ff <= req_sender;
         in_stamp_ff  <= req_stamp[SW-1:0];
      end
      pend_ff      <= pend_in;
      idx_ff       <= idx_in;
      out_send_ff  <= out_send_in;
      out_to_ff    <= out_to_in;
      out_bc_ff    <= out_bc_in;
      out_grant_ff <= out_grant_in;
      out_err_ff   <= out_err_in;
      out_done_ff  <= out_done_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_send_reply        = out_send_ff;
   assign rsp_reply_to          = out_to_ff;
   assign rsp_broadcast_request = out_bc_ff;
   assign rsp_granted           = out_grant_ff;
   assign rsp_error_code        = out_err_ff;
   assign rsp_done_total        = out_done_ff;
   assign rsp_last              = out_last_ff;

endmodule

`default_nettype wire

### sv/mex_controller.sv
// Controller: sequences accept, execute and release drain; owns the result valid.
`timescale 1ns / 1ps
`default_nettype none

module mex_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire mex_pkg::stat_type stat,
   output mex_pkg::ctrl_type      ctrl
);

   mex_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Output slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mex_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;
      req_stall    = 1'b1;

      unique case (state_ff)
         mex_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.ld_in = 1'b1;
               state_in   = mex_pkg::ST_EXEC;
            end
         end
         mex_pkg::ST_EXEC: begin
            if (stat.rel_pend) begin
               ctrl.rel_start = 1'b1;
               state_in       = mex_pkg::ST_DRAIN;
            end else if (out_free) begin
               ctrl.exec    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mex_pkg::ST_IDLE;
            end
         end
         mex_pkg::ST_DRAIN: begin
            if (!stat.bit_set) begin
               ctrl.skip = 1'b1;
            end else if (out_free) begin
               ctrl.emit    = 1'b1;
               rsp_valid_in = 1'b1;
               if (stat.emit_last) begin
                  state_in = mex_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mex_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/mutual_exclusion_node_unit.sv
// Top level of one Ricart-Agrawala mutual exclusion node.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall cmd, sender, stamp
//   rsp      out        rsp_valid/rsp_stall send_reply .. last
//   csr      in         csr_wr_en           csr_index, csr_wdata
//
// Each message is accepted in the idle state, then executed into the output register.
// A release with deferred peers then scans peer indexes from 1 up to the highest deferred peer
// (at most MAX_NODES-1) one bit per cycle, waiting on a set bit while the result is stalled.
// A stalled result only holds the execute or drain step; the next message is accepted meanwhile.
// Reset is synchronous and clears node state, registers and control at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mutual_exclusion_node_unit #(
   parameter int MAX_NODES  = mex_pkg::MAX_NODES_DEF,
   parameter int STAMP_BITS = mex_pkg::STAMP_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [mex_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mex_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mex_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [mex_pkg::ID_W-1:0]       req_sender,
   input  wire logic [mex_pkg::STAMP_W-1:0]    req_stamp,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_send_reply,
   output logic [mex_pkg::ID_W-1:0]            rsp_reply_to,
   output logic                                rsp_broadcast_request,
   output logic                                rsp_granted,
   output logic [mex_pkg::ERR_W-1:0]           rsp_error_code,
   output logic [mex_pkg::COUNT_W-1:0]         rsp_done_total,
   output logic                                rsp_last
);

   mex_pkg::ctrl_type ctrl;
   mex_pkg::stat_type stat;

   mex_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mex_datapath #(
      .MAX_NODES  (MAX_NODES),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_cmd               (req_cmd),
      .req_sender            (req_sender),
      .req_stamp             (req_stamp),
      .ctrl                  (ctrl),
      .stat                  (stat),
      .rsp_send_reply        (rsp_send_reply),
      .rsp_reply_to          (rsp_reply_to),
      .rsp_broadcast_request (rsp_broadcast_request),
      .rsp_granted           (rsp_granted),
      .rsp_error_code        (rsp_error_code),
      .rsp_done_total        (rsp_done_total),
      .rsp_last              (rsp_last)
   );

endmodule

`default_nettype wire

### sv/mex_checker.sv
// Port-level checks for the mutual exclusion node, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mex_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_send_reply,
   input wire logic [mex_pkg::ID_W-1:0]       rsp_reply_to,
   input wire logic                           rsp_broadcast_request,
   input wire logic                           rsp_granted,
   input wire logic [mex_pkg::ERR_W-1:0]      rsp_error_code,
   input wire logic [mex_pkg::COUNT_W-1:0]    rsp_done_total,
   input wire logic                           rsp_last
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_to) &&
      $stable(rsp_send_reply) && $stable(rsp_last) && $stable(rsp_done_total))
      else $error("stalled result changed");

   // No result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A reply goes out only on an error-free, non-broadcast transfer
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_reply |->
      rsp_error_code == mex_pkg::ERR_NONE && !rsp_broadcast_request)
      else $error("reply mixed with error or broadcast");

   // A broadcast or an error is always a single-transfer result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_broadcast_request || rsp_error_code != mex_pkg::ERR_NONE) |->
      rsp_last && !rsp_send_reply)
      else $error("broadcast or error not a single transfer");

   // A release error never comes with a grant
   a_err_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == mex_pkg::ERR_RELEASE |-> !rsp_granted)
      else $error("release error with grant");

endmodule

bind mutual_exclusion_node_unit mex_checker u_mex_checker (.*);

`default_nettype wire
